FILE: rtl/core/adaptive_mix_limiter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive mix limiter
// Implication checks sampled on the rising clock edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_MIX_LIMITER_ASSERT_SVH
`define ADAPTIVE_MIX_LIMITER_ASSERT_SVH

// Same-cycle implication.
`define AML_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adaptive_mix_limiter check failed");

// Next-cycle implication.
`define AML_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adaptive_mix_limiter check failed");

`endif

FILE: rtl/core/aml_pkg.sv
// ----------------------------------------------------------------------------
// aml_pkg
// Types, constants and microcode program of the adaptive mix limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package aml_pkg;

  localparam int XW  = 20;  // summed sample width
  localparam int SW  = 16;  // output sample width
  localparam int GW  = 4;   // gain step width
  localparam int PCW = 3;   // microcode step counter width

  localparam logic [GW-1:0] GAIN_MAX    = 4'd15;
  localparam logic [GW-1:0] GAIN_SEARCH = 4'd14;
  localparam logic [SW-1:0] S16_MAX     = 16'h7fff;
  localparam logic [SW-1:0] S16_MIN     = 16'h8000;

  typedef logic [PCW-1:0] pc_t;

  localparam pc_t ST_FETCH  = 3'd0;
  localparam pc_t ST_SCALE  = 3'd1;
  localparam pc_t ST_SEARCH = 3'd2;
  localparam pc_t ST_PASS   = 3'd3;
  localparam pc_t ST_CLIP   = 3'd4;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_IN,
    COND_FITS,
    COND_DONE,
    COND_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    G_KEEP,
    G_LOAD,
    G_TOP,
    G_DEC
  } gop_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_PASS,
    OUT_CLIP
  } oop_t;

  // One control word; gain and output ops apply only when the jump is not taken.
  typedef struct packed {
    logic  take_in;
    logic  sel_a;
    logic  ld_a;
    cond_t cond;
    pc_t   jump_to;
    pc_t   fall_to;
    gop_t  g_op;
    oop_t  out_op;
  } ctrl_t;

  typedef struct packed {
    logic take_in;
    logic sel_a;
    logic ld_a;
    gop_t g_op;
    oop_t out_op;
  } issue_t;

  typedef struct packed {
    logic fits;
    logic g_zero;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t cw;
    cw = '{take_in: 1'b0, sel_a: 1'b0, ld_a: 1'b0, cond: COND_NEVER,
           jump_to: ST_FETCH, fall_to: ST_FETCH, g_op: G_KEEP, out_op: OUT_NONE};
    case (pc)
      ST_FETCH: begin
        cw.take_in = 1'b1;
        cw.cond    = COND_NO_IN;
        cw.jump_to = ST_FETCH;
        cw.fall_to = ST_SCALE;
        cw.g_op    = G_LOAD;
      end
      ST_SCALE: begin
        cw.ld_a    = 1'b1;
        cw.cond    = COND_FITS;
        cw.jump_to = ST_PASS;
        cw.fall_to = ST_SEARCH;
        cw.g_op    = G_TOP;
      end
      ST_SEARCH: begin
        cw.sel_a   = 1'b1;
        cw.cond    = COND_DONE;
        cw.jump_to = ST_CLIP;
        cw.fall_to = ST_SEARCH;
        cw.g_op    = G_DEC;
      end
      ST_PASS: begin
        cw.cond    = COND_OUT_BUSY;
        cw.jump_to = ST_PASS;
        cw.fall_to = ST_FETCH;
        cw.out_op  = OUT_PASS;
      end
      ST_CLIP: begin
        cw.cond    = COND_OUT_BUSY;
        cw.jump_to = ST_CLIP;
        cw.fall_to = ST_FETCH;
        cw.out_op  = OUT_CLIP;
      end
      default: begin
        cw.cond    = COND_NEVER;
        cw.fall_to = ST_FETCH;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aml_sequencer.sv
// ----------------------------------------------------------------------------
// aml_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module aml_sequencer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            sum_valid,
  input  wire aml_pkg::stat_t  stat,
  output aml_pkg::issue_t      issue
);
  import aml_pkg::*;

  pc_t   pc;
  pc_t   pc_next;
  ctrl_t cw;
  logic  hit;

  assign cw = ucode(pc);

  always_comb begin
    case (cw.cond)
      COND_NEVER:    hit = 1'b0;
      COND_NO_IN:    hit = !sum_valid;
      COND_FITS:     hit = stat.fits;
      COND_DONE:     hit = stat.fits || stat.g_zero;
      COND_OUT_BUSY: hit = stat.out_busy;
      default:       hit = 1'b0;
    endcase
  end

  assign pc_next = hit ? cw.jump_to : cw.fall_to;

  always_comb begin
    issue.take_in = cw.take_in;
    issue.sel_a   = cw.sel_a;
    issue.ld_a    = cw.ld_a;
    issue.g_op    = hit ? G_KEEP : cw.g_op;
    issue.out_op  = hit ? OUT_NONE : cw.out_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/aml_datapath.sv
// ----------------------------------------------------------------------------
// aml_datapath
// Sample registers, shared sixteenths scaler, gain step and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aml_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [aml_pkg::XW-1:0] mixed_sum,
  input  wire logic                   frame_last,
  input  wire aml_pkg::issue_t        issue,
  output aml_pkg::stat_t              stat,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output logic [aml_pkg::SW-1:0]      sample_out,
  output logic                        clipped,
  output logic [aml_pkg::GW-1:0]      gain_step,
  output logic                        frame_end
);
  import aml_pkg::*;

  localparam int PW = XW + GW + 2;

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] a;
  logic [GW-1:0]        g_work;
  logic [GW-1:0]        gain_index;
  logic                 frame;

  logic signed [XW-1:0] operand;
  logic [GW:0]          factor;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] quot;
  logic [GW-1:0]        g_inc;
  logic                 x_pos;

  // trunc toward zero of operand * (g+1) / 16
  assign operand = issue.sel_a ? a : x;
  assign factor  = {1'b0, g_work} + (GW+1)'(1);
  assign prod    = PW'(operand) * PW'(signed'({1'b0, factor}));
  assign quot    = (prod + (prod[PW-1] ? PW'(15) : PW'(0))) >>> 4;

  assign stat.fits     = (&quot[PW-1:SW-1]) || !(|quot[PW-1:SW-1]);
  assign stat.g_zero   = (g_work == '0);
  assign stat.out_busy = res_valid && res_stall;

  assign g_inc = (g_work == GAIN_MAX) ? GAIN_MAX : g_work + GW'(1);
  assign x_pos = !x[XW-1] && (|x);

  always_ff @(posedge clk) begin
    if (issue.ld_a) begin
      a <= quot[XW-1:0];
    end
    case (issue.g_op)
      G_LOAD: begin
        x      <= mixed_sum;
        frame  <= frame_last;
        g_work <= gain_index;
      end
      G_TOP:   g_work <= GAIN_SEARCH;
      G_DEC:   g_work <= g_work - GW'(1);
      default: ;
    endcase
    case (issue.out_op)
      OUT_PASS: begin
        sample_out <= a[SW-1:0];
        clipped    <= 1'b0;
        gain_step  <= g_inc;
        frame_end  <= frame;
      end
      OUT_CLIP: begin
        sample_out <= x_pos ? S16_MAX : S16_MIN;
        clipped    <= 1'b1;
        gain_step  <= g_work;
        frame_end  <= frame;
      end
      default: ;
    endcase

    if (rst) begin
      gain_index <= GAIN_MAX;
      res_valid  <= 1'b0;
    end else begin
      case (issue.out_op)
        OUT_PASS: begin
          gain_index <= g_inc;
          res_valid  <= 1'b1;
        end
        OUT_CLIP: begin
          gain_index <= g_work;
          res_valid  <= 1'b1;
        end
        default: begin
          // drop valid once the transaction is taken
          if (res_valid && !res_stall) begin
            res_valid <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/adaptive_mix_limiter.sv
// Flow: a sample that fits goes through fetch, scale and pass; one that clips
//   goes through fetch, scale, a search over 1 to 15 gain steps from 14 down, and clip.
// A new sample is taken only in fetch, after the last result is registered; pass and
//   clip wait while the output is stalled. The search loop runs over the single shared scaler.
// Reset: synchronous; gain step returns to 15 (full gain), output empty.
// ----------------------------------------------------------------------------
// adaptive_mix_limiter
// Gain-stepping limiter for a summed audio sample, microcode controlled.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_mix_limiter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sum_valid,
  output logic             sum_stall,
  input  wire logic [19:0] mixed_sum,
  input  wire logic        frame_last,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [15:0]      sample_out,
  output logic             clipped,
  output logic [3:0]       gain_step,
  output logic             frame_end
);
  import aml_pkg::*;

  issue_t issue;
  stat_t  stat;

  // hold off input while in reset or outside the fetch step
  assign sum_stall = rst || !issue.take_in;

  aml_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .stat      (stat),
    .issue     (issue)
  );

  aml_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .mixed_sum  (mixed_sum),
    .frame_last (frame_last),
    .issue      (issue),
    .stat       (stat),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .sample_out (sample_out),
    .clipped    (clipped),
    .gain_step  (gain_step),
    .frame_end  (frame_end)
  );

endmodule

`default_nettype wire

FILE: rtl/core/aml_checker.sv
// ----------------------------------------------------------------------------
// aml_checker
// Port-level checks on the limiter result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adaptive_mix_limiter_assert.svh"

module aml_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [15:0] sample_out,
  input wire logic        clipped,
  input wire logic [3:0]  gain_step
);

  // a stalled transaction stays offered
  `AML_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid)

  // saturation only to full scale
  `AML_ASSERT_IMPLY(a_clip_full, clk, rst, res_valid && clipped, sample_out == 16'h7fff || sample_out == 16'h8000)

  // a clip always lowers the gain below full
  `AML_ASSERT_IMPLY(a_clip_gain, clk, rst, res_valid && clipped, gain_step != 4'd15)

  // a sample that fits leaves a gain step above zero
  `AML_ASSERT_IMPLY(a_pass_gain, clk, rst, res_valid && !clipped, gain_step != 4'd0)

endmodule

bind adaptive_mix_limiter aml_checker u_chk (.*);

`default_nettype wire

FILE: test/tb_adaptive_mix_limiter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_mix_limiter
// Drives summed samples through the limiter with bursty input and a
// patterned output stall. A gain tracker predicts every result, and each
// output transaction is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_adaptive_mix_limiter;
  import aml_pkg::*;

  localparam int SAMPLE_HI  = 32767;
  localparam int SAMPLE_LO  = -32768;
  localparam int SUM_HI     = 524287;
  localparam int SUM_LO     = -524288;
  localparam int N_RANDOM   = 930;
  localparam int HOLD_AT    = 200;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 40;

  typedef struct {
    logic [XW-1:0] sum;
    logic          last;
  } mix_sum_t;

  typedef struct {
    logic [SW-1:0] sample;
    logic          clip;
    logic [GW-1:0] gain;
    logic          last;
  } mix_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          sum_valid = 1'b0;
  logic          sum_stall;
  logic [19:0]   mixed_sum = '0;
  logic          frame_last = 1'b0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  logic [15:0]   sample_out;
  logic          clipped;
  logic [3:0]    gain_step;
  logic          frame_end;

  mix_sum_t      pending_sums[$];
  mix_result_t   expected_mix[$];
  logic [GW-1:0] gain_track;
  int            sums_total = 0;
  int            sums_sent = 0;
  int            results_seen = 0;
  int            mismatches = 0;

  adaptive_mix_limiter u_dut (
    .clk        (clk),
    .rst        (rst),
    .sum_valid  (sum_valid),
    .sum_stall  (sum_stall),
    .mixed_sum  (mixed_sum),
    .frame_last (frame_last),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .sample_out (sample_out),
    .clipped    (clipped),
    .gain_step  (gain_step),
    .frame_end  (frame_end)
  );

  always #5 clk = ~clk;

  function automatic int scale_sixteenths(int v, logic [GW-1:0] step);
    return (v * (int'(step) + 1)) / 16;
  endfunction

  function automatic bit fits_sample(int v);
    return v <= SAMPLE_HI && v >= SAMPLE_LO;
  endfunction

  // Advance the gain tracker by one sample and queue the result it implies.
  task automatic predict_limiter(logic [XW-1:0] raw, logic last);
    int            x;
    int            a;
    logic [GW-1:0] step;
    mix_result_t   r;
    x = int'($signed(raw));
    a = scale_sixteenths(x, gain_track);
    r.last = last;
    if (fits_sample(a)) begin
      r.sample = a[SW-1:0];
      r.clip   = 1'b0;
      if (gain_track != GAIN_MAX) gain_track = gain_track + 1'b1;
    end else begin
      // rescale the attenuated value, not x, stopping at step 0
      step = GAIN_SEARCH;
      while (step != 0 && !fits_sample(scale_sixteenths(a, step)))
        step = step - 1'b1;
      gain_track = step;
      r.clip     = 1'b1;
      r.sample   = (x > 0) ? S16_MAX : S16_MIN;
    end
    r.gain = gain_track;
    expected_mix.push_back(r);
  endtask

  task automatic add_sum(int x, logic last);
    mix_sum_t s;
    s.sum  = x[XW-1:0];
    s.last = last;
    pending_sums.push_back(s);
    sums_total++;
  endtask

  function automatic int random_sum();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) return $urandom_range(0, 80000) - 40000;
    if (pick <= 6) return $urandom_range(0, 280000) - 140000;
    if (pick <= 8) return $urandom_range(0, SUM_HI - SUM_LO) + SUM_LO;
    case ($urandom_range(0, 5))
      0: return SUM_HI;
      1: return SUM_LO;
      2: return 0;
      3: return SAMPLE_HI + 1;
      4: return SAMPLE_LO - 1;
      default: return SAMPLE_LO;
    endcase
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    mix_sum_t s;
    if (rst) begin
      sum_valid <= 1'b0;
      gain_track = GAIN_MAX;
    end else begin
      if (sum_valid && !sum_stall) begin
        predict_limiter(mixed_sum, frame_last);
        sums_sent++;
      end
      // hold a stalled transaction unchanged
      if (!(sum_valid && sum_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          sum_valid <= 1'b0;
        end else if (pending_sums.size() > 0) begin
          s = pending_sums.pop_front();
          sum_valid  <= 1'b1;
          mixed_sum  <= s.sum;
          frame_last <= s.last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          sum_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall pattern in phases, one long hold-off, in-order compare.
  int  stall_mode = 0;
  int  phase_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    mix_result_t e;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (expected_mix.size() == 0) begin
          $error("result transaction with nothing expected: sample_out %0d",
                 $signed(sample_out));
          mismatches++;
        end else begin
          e = expected_mix.pop_front();
          if (sample_out !== e.sample) begin
            $error("sample_out expected %0d actual %0d", $signed(e.sample),
                   $signed(sample_out));
            mismatches++;
          end
          if (clipped !== e.clip) begin
            $error("clipped expected %0b actual %0b", e.clip, clipped);
            mismatches++;
          end
          if (gain_step !== e.gain) begin
            $error("gain_step expected %0d actual %0d", e.gain, gain_step);
            mismatches++;
          end
          if (frame_end !== e.last) begin
            $error("frame_end expected %0b actual %0b", e.last, frame_end);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        res_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          phase_left = $urandom_range(20, 200);
        end else begin
          phase_left--;
        end
        case (stall_mode)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 2) == 0);
          default: res_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    // directed: extremes, clip boundaries, search floor, gain recovery
    add_sum(0, 1'b0);
    add_sum(1, 1'b1);
    add_sum(-1, 1'b0);
    add_sum(SAMPLE_HI, 1'b0);
    add_sum(SAMPLE_LO, 1'b1);
    add_sum(SUM_LO, 1'b0);
    add_sum(0, 1'b0);
    add_sum(SUM_HI, 1'b1);
    add_sum(SAMPLE_HI + 1, 1'b0);
    add_sum(SAMPLE_LO - 1, 1'b0);
    add_sum(65535, 1'b1);
    add_sum(-65536, 1'b0);
    for (int i = 0; i < 6; i++) add_sum(i * 1000 - 2500, i[0]);
    add_sum(SUM_HI, 1'b0);
    add_sum(SUM_LO, 1'b1);
    add_sum(262143, 1'b0);
    add_sum(-262144, 1'b1);
    add_sum(0, 1'b0);
    for (int i = 0; i < N_RANDOM; i++) add_sum(random_sum(), $urandom_range(0, 1));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (sums_sent == sums_total);
    wait (expected_mix.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_mix.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: adaptive_mix_limiter.f
+incdir+rtl/core
rtl/core/aml_pkg.sv
rtl/core/aml_sequencer.sv
rtl/core/aml_datapath.sv
rtl/core/adaptive_mix_limiter.sv
rtl/core/aml_checker.sv
test/tb_adaptive_mix_limiter.sv
